// ===== hdl/arc_pkg.sv =====
// Package: widths, latencies and payload types of the arc radius residual block.
`default_nettype none
package arc_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int UNIT_FRAC_BITS = 30;
  localparam int VAL_FRAC       = 16;

  // Sum of squares of two (W+1)-bit magnitudes, root width, divider width.
  localparam int SUMSQ_W    = 2 * COORD_WIDTH + 3;
  localparam int SQ_STEPS   = (SUMSQ_W + 1) / 2;
  localparam int DIST_W     = SQ_STEPS;
  localparam int GRAD_NUM_W = DIST_W + VAL_FRAC;
  localparam int UNIT_NUM_W = COORD_WIDTH + 1 + UNIT_FRAC_BITS;
  localparam int DIV_NUM_W  = (GRAD_NUM_W > UNIT_NUM_W) ? GRAD_NUM_W : UNIT_NUM_W;
  localparam int LANE_LAT   = 4 + SQ_STEPS + DIV_NUM_W;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic        [COORD_WIDTH-2:0] arc_radius;
  } arc_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]    start_residual;
    logic        [COORD_WIDTH-1:0]    start_radius_grad;
    logic signed [UNIT_FRAC_BITS+1:0] start_unit_x;
    logic signed [UNIT_FRAC_BITS+1:0] start_unit_y;
    logic signed [COORD_WIDTH-1:0]    end_residual;
    logic        [COORD_WIDTH-1:0]    end_radius_grad;
    logic signed [UNIT_FRAC_BITS+1:0] end_unit_x;
    logic signed [UNIT_FRAC_BITS+1:0] end_unit_y;
    logic        [1:0]                degenerate_flags;
  } arc_rsp_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0]    residual;
    logic        [COORD_WIDTH-1:0]    grad;
    logic signed [UNIT_FRAC_BITS+1:0] unit_x;
    logic signed [UNIT_FRAC_BITS+1:0] unit_y;
    logic                             degen;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== hdl/arc_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module arc_isqrt #(
  parameter int NW = arc_pkg::SUMSQ_W
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [NW-1:0]           radicand,
  output logic      [(NW+1)/2-1:0]     root
);
  import arc_pkg::*;

  localparam int STEPS = (NW + 1) / 2;
  localparam int PW    = 2 * STEPS;
  localparam int RMW   = STEPS + 3;

  logic [RMW-1:0]   rem_q  [STEPS];
  logic [STEPS-1:0] root_q [STEPS];
  logic [PW-1:0]    rad_q  [STEPS-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RMW-1:0]   r_in, cur, trial, r_nx;
    logic [STEPS-1:0] q_in, q_nx;
    logic [PW-1:0]    n_in;
    logic             ge;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = PW'(radicand);
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign q_in = root_q[k-1];
      assign n_in = rad_q[k-1];
    end
    assign cur   = {r_in[RMW-3:0], n_in[PW-1-2*k -: 2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge    = cur >= trial;
    assign r_nx  = ge ? cur - trial : cur;
    assign q_nx  = {q_in[STEPS-2:0], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= r_nx;
        root_q[k] <= q_nx;
      end
    end
    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[k] <= n_in;
        end
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule
`default_nettype wire

// ===== hdl/arc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module arc_div #(
  parameter int NW = arc_pkg::DIV_NUM_W,
  parameter int DW = arc_pkg::DIST_W
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quot
);
  import arc_pkg::*;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] q_q   [NW];
  logic [NW-1:0] num_q [NW-1];
  logic [DW-1:0] den_q [NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW-1:0] r_in, d_in, r_nx;
    logic [NW-1:0] n_in, q_in, q_nx;
    logic [DW:0]   cur, diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = num;
      assign d_in = den;
    end else begin : g_rest
      assign r_in = rem_q[k-1];
      assign q_in = q_q[k-1];
      assign n_in = num_q[k-1];
      assign d_in = den_q[k-1];
    end
    assign cur  = {r_in, n_in[NW-1-k]};
    assign ge   = cur >= {1'b0, d_in};
    assign diff = cur - {1'b0, d_in};
    assign r_nx = ge ? diff[DW-1:0] : cur[DW-1:0];
    assign q_nx = {q_in[NW-2:0], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= r_nx;
        q_q[k]   <= q_nx;
      end
    end
    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num_q[k] <= n_in;
          den_q[k] <= d_in;
        end
      end
    end
  end

  assign quot = q_q[NW-1];

endmodule
`default_nettype wire

// ===== hdl/arc_lane.sv =====
// One endpoint lane: distance, residual, radius gradient and unit direction.
`default_nettype none
module arc_lane (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [arc_pkg::COORD_WIDTH-1:0] cx,
  input  wire logic signed [arc_pkg::COORD_WIDTH-1:0] cy,
  input  wire logic signed [arc_pkg::COORD_WIDTH-1:0] px,
  input  wire logic signed [arc_pkg::COORD_WIDTH-1:0] py,
  input  wire logic        [arc_pkg::COORD_WIDTH-2:0] rad,
  output arc_pkg::lane_res_t                       res
);
  import arc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = UNIT_FRAC_BITS;
  localparam int D1 = 2 + SQ_STEPS;
  localparam int D2 = DIV_NUM_W;

  typedef struct packed {
    logic [W:0]   ax;
    logic [W:0]   ay;
    logic         sx;
    logic         sy;
    logic [W-2:0] rad;
  } side1_t;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [W-2:0]      rad;
    logic [DIST_W-1:0] span;
  } side2_t;

  // stage 1: differences and magnitudes
  logic signed [W:0] dx, dy;
  side1_t            s1;
  assign dx = {px[W-1], px} - {cx[W-1], cx};
  assign dy = {py[W-1], py} - {cy[W-1], cy};

  always_ff @(posedge clk) begin
    if (en) begin
      s1.ax  <= dx[W] ? (W+1)'(-dx) : dx;
      s1.ay  <= dy[W] ? (W+1)'(-dy) : dy;
      s1.sx  <= dx[W];
      s1.sy  <= dy[W];
      s1.rad <= rad;
    end
  end

  // stages 2 and 3: squares, sum
  logic [2*W+1:0]   sqx, sqy;
  logic [SUMSQ_W-1:0] sum;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= s1.ax * s1.ax;
      sqy <= s1.ay * s1.ay;
      sum <= SUMSQ_W'(sqx) + SUMSQ_W'(sqy);
    end
  end

  logic [DIST_W-1:0] span;
  arc_isqrt #(.NW(SUMSQ_W)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .root     (span)
  );

  side1_t side1_q [D1];
  always_ff @(posedge clk) begin
    if (en) begin
      side1_q[0] <= s1;
      for (int i = 1; i < D1; i++) side1_q[i] <= side1_q[i-1];
    end
  end

  side1_t sd;
  assign sd = side1_q[D1-1];

  logic [DIV_NUM_W-1:0] q_grad, q_ux, q_uy;

  arc_div #(.NW(DIV_NUM_W), .DW(DIST_W)) u_div_grad (
    .clk (clk), .en (en),
    .num (DIV_NUM_W'({span, {VAL_FRAC{1'b0}}})),
    .den (DIST_W'(sd.rad)),
    .quot(q_grad)
  );
  arc_div #(.NW(DIV_NUM_W), .DW(DIST_W)) u_div_ux (
    .clk (clk), .en (en),
    .num (DIV_NUM_W'({sd.ax, {F{1'b0}}})),
    .den (span),
    .quot(q_ux)
  );
  arc_div #(.NW(DIV_NUM_W), .DW(DIST_W)) u_div_uy (
    .clk (clk), .en (en),
    .num (DIV_NUM_W'({sd.ay, {F{1'b0}}})),
    .den (span),
    .quot(q_uy)
  );

  side2_t side2_q [D2];
  always_ff @(posedge clk) begin
    if (en) begin
      side2_q[0] <= '{sx: sd.sx, sy: sd.sy, rad: sd.rad, span: span};
      for (int i = 1; i < D2; i++) side2_q[i] <= side2_q[i-1];
    end
  end

  // final stage: saturation and sign
  localparam logic signed [W+2:0] RES_LO = {4'b1111, {(W-1){1'b0}}};
  side2_t            st;
  logic signed [W+2:0] diff;
  logic              zero, gsat;
  logic [F+1:0]      mx, my;
  lane_res_t         res_next;
  assign st = side2_q[D2-1];

  always_comb begin
    zero = st.span == '0;
    diff = $signed({4'b0000, st.rad}) - $signed({{(W+3-DIST_W){1'b0}}, st.span});
    res_next.residual = (diff < RES_LO) ? {1'b1, {(W-1){1'b0}}} : diff[W-1:0];
    gsat = (st.rad == '0) || (|q_grad[DIV_NUM_W-1:W]);
    res_next.grad = gsat ? {W{1'b1}} : q_grad[W-1:0];
    mx = {1'b0, q_ux[F:0]};
    my = {1'b0, q_uy[F:0]};
    res_next.unit_x = zero ? '0 : (st.sx ? (F+2)'(-mx) : mx);
    res_next.unit_y = zero ? '0 : (st.sy ? (F+2)'(-my) : my);
    res_next.degen  = zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/arc_outq.sv =====
// Two-entry output queue between the lane pipeline and the result channel.
`default_nettype none
module arc_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire arc_pkg::arc_rsp_t din,
  output logic                   full,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output arc_pkg::arc_rsp_t      rsp_data
);
  import arc_pkg::*;

  logic [1:0] count, count_next;
  arc_rsp_t   slot0, slot1;
  logic       pop;

  assign pop       = (count != 2'd0) && !rsp_stall;
  assign full      = count == 2'd2;
  assign rsp_valid = count != 2'd0;
  assign rsp_data  = slot0;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/arc_radius_constraint_residual.sv =====
// Top level: arc radius constraint residual and Jacobian terms, two endpoint lanes.
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_data  (arc_req_t)
// rsp     | out       | rsp_valid / rsp_stall | rsp_data  (arc_rsp_t)
//
// Throughput: one request per cycle while the output queue is not full. The
// pipeline depth is set by the one-bit-per-stage square root (W+2 stages) and
// the one-bit-per-stage dividers (DIV_NUM_W stages) in each lane.
// Reset: synchronous, clears the valid pipe and the output queue count.
// Stalls: the lane pipeline freezes only when the two-entry output queue is
// full; req_stall is the registered full flag.
`default_nettype none
module arc_radius_constraint_residual (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire arc_pkg::arc_req_t req_data,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output arc_pkg::arc_rsp_t      rsp_data
);
  import arc_pkg::*;

  logic      en, full, push;
  logic [LANE_LAT-1:0] vp;
  lane_res_t res_s, res_e;
  arc_rsp_t  merged;

  // whole lane pipeline advances together unless the queue is full
  assign en        = !full;
  assign req_stall = full;
  assign push      = en && vp[LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LANE_LAT-2:0], req_valid};
    end
  end

  arc_lane u_lane_start (
    .clk (clk), .en (en),
    .cx  (req_data.center_x), .cy (req_data.center_y),
    .px  (req_data.start_x),  .py (req_data.start_y),
    .rad (req_data.arc_radius),
    .res (res_s)
  );

  arc_lane u_lane_end (
    .clk (clk), .en (en),
    .cx  (req_data.center_x), .cy (req_data.center_y),
    .px  (req_data.end_x),    .py (req_data.end_y),
    .rad (req_data.arc_radius),
    .res (res_e)
  );

  // merge the two lanes into one result
  always_comb begin
    merged.start_residual    = res_s.residual;
    merged.start_radius_grad = res_s.grad;
    merged.start_unit_x      = res_s.unit_x;
    merged.start_unit_y      = res_s.unit_y;
    merged.end_residual      = res_e.residual;
    merged.end_radius_grad   = res_e.grad;
    merged.end_unit_x        = res_e.unit_x;
    merged.end_unit_y        = res_e.unit_y;
    merged.degenerate_flags  = {res_e.degen, res_s.degen};
  end

  arc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (merged),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

`ifndef ASSERT_OFF
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (vp[LANE_LAT-1] && !en) |=> vp[LANE_LAT-1])
    else $error("result lost while pipeline frozen");
`endif
`ifndef ASSERT_OFF
  a_start_degen: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.degenerate_flags[0]) |->
      (rsp_data.start_unit_x == '0 && rsp_data.start_unit_y == '0))
    else $error("start direction nonzero on degenerate point");
`endif
`ifndef ASSERT_OFF
  a_end_degen: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.degenerate_flags[1]) |->
      (rsp_data.end_unit_x == '0 && rsp_data.end_unit_y == '0))
    else $error("end direction nonzero on degenerate point");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/arc_radius_constraint_residual_test.sv =====
// Testbench for the arc radius residual block: random and corner arcs vs. a behavioral model.
`timescale 1ns / 100ps
`default_nettype none
module arc_radius_constraint_residual_test;
  import arc_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = UNIT_FRAC_BITS;
  localparam int LAT = LANE_LAT + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  arc_req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  arc_rsp_t rsp_data;

  arc_radius_constraint_residual uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
  );

  always #2 clk = ~clk;

  arc_req_t pending_arcs[$];   // requests not yet sent
  arc_rsp_t expected_terms[$]; // predicted responses, oldest first
  bit failed = 1'b0;
  bit stim_done = 1'b0;

  // Integer square root, floor, of a sum of squares (fits in 67 bits).
  function automatic logic [DIST_W-1:0] root_floor(logic [SUMSQ_W-1:0] n);
    logic [DIST_W-1:0] r;
    logic [DIST_W-1:0] c;
    r = '0;
    for (int i = DIST_W - 1; i >= 0; i--) begin
      c = r | (DIST_W'(1) << i);
      if ({{(2*DIST_W-SUMSQ_W){1'b0}}, n} >= (2*DIST_W)'(c) * (2*DIST_W)'(c)) r = c;
    end
    return r;
  endfunction

  // Terms for one endpoint: residual, gradient, unit direction, coincident flag.
  function automatic lane_res_t endpoint_terms(logic signed [W-1:0] cx, logic signed [W-1:0] cy,
                                               logic signed [W-1:0] px, logic signed [W-1:0] py,
                                               logic [W-2:0] rad);
    lane_res_t t;
    logic signed [W:0] dx, dy;
    logic [W:0] ax, ay;
    logic [SUMSQ_W-1:0] sumsq;
    logic [DIST_W-1:0] span;
    logic signed [DIST_W+1:0] res, res_hi, res_lo;
    logic [127:0] q, ux, uy;
    dx = $signed({px[W-1], px}) - $signed({cx[W-1], cx});
    dy = $signed({py[W-1], py}) - $signed({cy[W-1], cy});
    ax = dx[W] ? -dx : dx;
    ay = dy[W] ? -dy : dy;
    sumsq = SUMSQ_W'(ax) * SUMSQ_W'(ax) + SUMSQ_W'(ay) * SUMSQ_W'(ay);
    span = root_floor(sumsq);
    res = $signed({3'b000, rad}) - $signed({2'b00, span});
    res_hi = (DIST_W+2)'({(W-1){1'b1}});
    res_lo = -res_hi - (DIST_W+2)'(1);
    if (res > res_hi) t.residual = {1'b0, {(W-1){1'b1}}};
    else if (res < res_lo) t.residual = {1'b1, {(W-1){1'b0}}};
    else t.residual = res[W-1:0];
    if (rad == 0) t.grad = '1;
    else begin
      q = ({94'b0, span} << VAL_FRAC) / rad;
      t.grad = (q > 128'({W{1'b1}})) ? '1 : q[W-1:0];
    end
    if (span == 0) begin
      t.unit_x = '0;
      t.unit_y = '0;
    end else begin
      ux = ({95'b0, ax} << F) / span;
      uy = ({95'b0, ay} << F) / span;
      t.unit_x = dx[W] ? -ux[F+1:0] : ux[F+1:0];
      t.unit_y = dy[W] ? -uy[F+1:0] : uy[F+1:0];
    end
    t.degen = (span == 0);
    return t;
  endfunction

  function automatic arc_rsp_t arc_terms(arc_req_t a);
    arc_rsp_t r;
    lane_res_t s, e;
    s = endpoint_terms(a.center_x, a.center_y, a.start_x, a.start_y, a.arc_radius);
    e = endpoint_terms(a.center_x, a.center_y, a.end_x, a.end_y, a.arc_radius);
    r.start_residual = s.residual;
    r.start_radius_grad = s.grad;
    r.start_unit_x = s.unit_x;
    r.start_unit_y = s.unit_y;
    r.end_residual = e.residual;
    r.end_radius_grad = e.grad;
    r.end_unit_x = e.unit_x;
    r.end_unit_y = e.unit_y;
    r.degenerate_flags = {e.degen, s.degen};
    return r;
  endfunction

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return W'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-2:0] rand_radius();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return (W-1)'($urandom_range(0, 3));
      2: return (W-1)'($urandom_range(0, 1 << 20));
      default: return (W-1)'($urandom);
    endcase
  endfunction

  function automatic arc_req_t make_arc(logic [W-1:0] cx, logic [W-1:0] cy,
                                        logic [W-1:0] sx, logic [W-1:0] sy,
                                        logic [W-1:0] ex, logic [W-1:0] ey,
                                        logic [W-2:0] rad);
    arc_req_t a;
    a.center_x = cx; a.center_y = cy;
    a.start_x = sx; a.start_y = sy;
    a.end_x = ex; a.end_y = ey;
    a.arc_radius = rad;
    return a;
  endfunction

  initial begin
    logic [W-1:0] mx, mn, cx, cy;
    arc_req_t a;
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    // Directed: coincident points, zero radius, extreme spans, axis directions.
    pending_arcs.push_back(make_arc(0, 0, 0, 0, 0, 0, 0));
    pending_arcs.push_back(make_arc(0, 0, 0, 0, 32'h10000, 0, 31'h10000));
    pending_arcs.push_back(make_arc(5, 7, 5, 7, 5, 7, 1));
    pending_arcs.push_back(make_arc(0, 0, 3, 4, 0, 0, 0));
    pending_arcs.push_back(make_arc(mn, mn, mx, mx, mn, mx, 1));
    pending_arcs.push_back(make_arc(mx, mx, mn, mn, mx, mn, '1));
    pending_arcs.push_back(make_arc(mn, 0, mx, 0, mn, mn, 0));
    pending_arcs.push_back(make_arc(0, 0, 0, 32'h10000, 0, -32'sh10000, 31'h10000));
    pending_arcs.push_back(make_arc(0, 0, -32'sh10000, 0, 32'h10000, 0, '1));
    pending_arcs.push_back(make_arc(0, 0, 1, 1, -1, -1, 1));
    pending_arcs.push_back(make_arc('1, '1, '1, '1, '1, '1, '1));
    pending_arcs.push_back(make_arc(mx, mn, mx, mn, mn, mx, 2));
    pending_arcs.push_back(make_arc(0, 0, 32'h00030000, 32'h00040000, 1, 0, 31'h00050000));
    pending_arcs.push_back(make_arc(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa,
                                    32'h55555555, 0, 0, 31'h2aaaaaaa));
    // Random: mostly points near a circle, some anywhere, some on center.
    for (int i = 0; i < 1440; i++) begin
      cx = rand_coord();
      cy = rand_coord();
      a = make_arc(cx, cy, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_radius());
      if ($urandom_range(0, 2) != 0) begin
        a.arc_radius = (W-1)'($urandom_range(1, 1 << 24));
        a.start_x = cx + W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        a.start_y = cy + W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        a.end_x = cx + W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        a.end_y = cy + W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      end
      if ($urandom_range(0, 15) == 0) begin
        a.start_x = cx;
        a.start_y = cy;
      end
      if ($urandom_range(0, 15) == 0) begin
        a.end_x = cx;
        a.end_y = cy;
      end
      pending_arcs.push_back(a);
    end
    stim_done = 1'b1;
  end

  // Idle draws: half the time a burst with no gaps.
  function automatic int draw_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  int send_gap = 0;

  // Driver: holds a request until accepted, then waits its drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      expected_terms.push_back(arc_terms(req_data));
      send_gap = draw_gap();
      if (send_gap == 0 && pending_arcs.size() > 0) begin
        req_data <= pending_arcs.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (pending_arcs.size() > 0) begin
        req_valid <= 1'b1;
        req_data <= pending_arcs.pop_front();
      end
    end
  end

  int stall_left = 0;

  // Monitor: checks each accepted response, then draws the next stall run.
  always @(posedge clk) begin
    arc_rsp_t exp_r;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_terms.size() == 0) begin
          $display("%0t: response with none expected: %h", $time, rsp_data);
          failed = 1'b1;
        end else begin
          exp_r = expected_terms.pop_front();
          if (exp_r.start_residual !== rsp_data.start_residual)
            $display("%0t: start_residual exp %h got %h", $time,
                     exp_r.start_residual, rsp_data.start_residual);
          if (exp_r.start_radius_grad !== rsp_data.start_radius_grad)
            $display("%0t: start_radius_grad exp %h got %h", $time,
                     exp_r.start_radius_grad, rsp_data.start_radius_grad);
          if (exp_r.start_unit_x !== rsp_data.start_unit_x)
            $display("%0t: start_unit_x exp %h got %h", $time,
                     exp_r.start_unit_x, rsp_data.start_unit_x);
          if (exp_r.start_unit_y !== rsp_data.start_unit_y)
            $display("%0t: start_unit_y exp %h got %h", $time,
                     exp_r.start_unit_y, rsp_data.start_unit_y);
          if (exp_r.end_residual !== rsp_data.end_residual)
            $display("%0t: end_residual exp %h got %h", $time,
                     exp_r.end_residual, rsp_data.end_residual);
          if (exp_r.end_radius_grad !== rsp_data.end_radius_grad)
            $display("%0t: end_radius_grad exp %h got %h", $time,
                     exp_r.end_radius_grad, rsp_data.end_radius_grad);
          if (exp_r.end_unit_x !== rsp_data.end_unit_x)
            $display("%0t: end_unit_x exp %h got %h", $time,
                     exp_r.end_unit_x, rsp_data.end_unit_x);
          if (exp_r.end_unit_y !== rsp_data.end_unit_y)
            $display("%0t: end_unit_y exp %h got %h", $time,
                     exp_r.end_unit_y, rsp_data.end_unit_y);
          if (exp_r.degenerate_flags !== rsp_data.degenerate_flags)
            $display("%0t: degenerate_flags exp %b got %b", $time,
                     exp_r.degenerate_flags, rsp_data.degenerate_flags);
          if (exp_r !== rsp_data) failed = 1'b1;
        end
        stall_left = draw_gap();
      end
      // Stall only while a response is waiting or a run is in progress.
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Reset, then wait until all requests are sent and all expected responses are checked, then let the pipeline drain.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_arcs.size() == 0 && !req_valid);
    wait (expected_terms.size() == 0);
    repeat (LAT + 40) @(posedge clk);
    if (!failed && expected_terms.size() == 0) begin
      $display("** arc_radius_constraint_residual: PASSED **");
    end else begin
      $display("** arc_radius_constraint_residual: FAILED **");
    end
    $finish;
  end

  // Timeout: ~1500 requests, each with its drawn gaps and stalls plus the pipeline.
  initial begin
    #2000000;
    $display("** arc_radius_constraint_residual: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
